>>> hw/rtl/mct_pkg.sv
// ----------------------------------------------------------------------------
// Marker count table package
// Shared sizes, item codes, types and helper functions of the marker count
// table.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int unsigned NUM_MARKERS = 128;
	localparam int unsigned NUM_COMMS   = 1024;

	// Item field widths.
	localparam int unsigned KIND_W = 2;
	localparam int unsigned MARK_W = 7;
	localparam int unsigned KCNT_W = 8;
	localparam int unsigned WGT_W  = 16;
	localparam int unsigned COMM_W = 10;

	// Result field widths.
	localparam int unsigned DCOMP_W    = 18;
	localparam int unsigned DCONT_W    = 25;
	localparam int unsigned PRES_OUT_W = 8;
	localparam int unsigned EXC_OUT_W  = 22;
	localparam int unsigned PRES_OUT_MAX = 255;
	localparam int unsigned EXC_OUT_MAX  = 4194303;

	// Stored widths.
	localparam int unsigned CNT_W     = 15;
	localparam int unsigned CNT_DEPTH = NUM_COMMS * NUM_MARKERS;
	localparam int unsigned CNT_AW    = $clog2(CNT_DEPTH);
	localparam int unsigned STAT_AW   = $clog2(NUM_COMMS);
	localparam int unsigned PRES_W    = $clog2(NUM_MARKERS + 1);
	localparam int unsigned EXC_W     = $clog2(NUM_MARKERS * ((2 ** CNT_W) - 2) + 1);
	localparam int unsigned STAT_W    = PRES_W + EXC_W;

	// Query delta terms: indicator change in [-1,1], excess change in [-255,255].
	localparam int unsigned IND_W = 2;
	localparam int unsigned CON_W = KCNT_W + 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_MOVE  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [PRES_W-1:0] pres;
		logic [EXC_W-1:0]  exc;
	} stat_t;

	// Decoded item, latched at acceptance.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              m_ok;
		logic              s_ok;
		logic              d_ok;
		logic              same_comm;
	} req_t;

	// Updated entries and query terms of one item.
	typedef struct packed {
		logic [CNT_W-1:0]       ns_new;
		logic [CNT_W-1:0]       nt_new;
		stat_t                  ss_new;
		stat_t                  ts_new;
		logic                   wr_src;
		logic                   wr_tgt;
		logic signed [IND_W-1:0] ind;
		logic signed [CON_W-1:0] con;
	} upd_t;

	function automatic logic [CNT_AW-1:0] cnt_index(input logic [COMM_W-1:0] comm,
			input logic [MARK_W-1:0] mark);
		return CNT_AW'(32'(comm) * NUM_MARKERS + 32'(mark));
	endfunction

	function automatic logic [PRES_OUT_W-1:0] sat_pres(input logic [PRES_W-1:0] p);
		if (32'(p) > PRES_OUT_MAX) begin
			return PRES_OUT_W'(PRES_OUT_MAX);
		end
		return PRES_OUT_W'(p);
	endfunction

	function automatic logic [EXC_OUT_W-1:0] sat_exc(input logic [EXC_W-1:0] e);
		if (32'(e) > EXC_OUT_MAX) begin
			return EXC_OUT_W'(EXC_OUT_MAX);
		end
		return EXC_OUT_W'(e);
	endfunction

endpackage

>>> hw/rtl/mct_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/mct_calc.sv
// ----------------------------------------------------------------------------
// Marker count update
// Computes new source and target counts and community totals for add and
// move items, and the indicator and excess terms of a move query.
// ----------------------------------------------------------------------------
module mct_calc (
	input  mct_pkg::req_t                     req,
	input  logic [mct_pkg::KCNT_W-1:0]        k,
	input  logic [mct_pkg::CNT_W-1:0]         ns,
	input  logic [mct_pkg::CNT_W-1:0]         nt,
	input  mct_pkg::stat_t                    ss,
	input  mct_pkg::stat_t                    ts,
	output mct_pkg::upd_t                     upd
);

	localparam int unsigned SUM_W = mct_pkg::CNT_W + 1;

	function automatic logic [SUM_W-1:0] over_one(input logic [SUM_W-1:0] x);
		return (x > SUM_W'(1)) ? x - SUM_W'(1) : '0;
	endfunction

	logic [SUM_W-1:0]          k_ext;
	logic [SUM_W-1:0]          sum_t;
	logic [mct_pkg::CNT_W-1:0] nt_sat;
	logic [mct_pkg::CNT_W-1:0] ns_flr;
	logic [SUM_W-1:0]          up_t;
	logic [SUM_W-1:0]          dn_s;
	logic                      pres_up;
	logic                      pres_dn;
	logic                      all_ok;
	logic                      do_src;
	logic                      do_tgt;
	logic                      do_query;

	always_comb begin
		k_ext  = SUM_W'(k);
		sum_t  = SUM_W'(nt) + k_ext;
		nt_sat = (sum_t > SUM_W'(mct_pkg::COUNT_MAX)) ? mct_pkg::COUNT_MAX
			: sum_t[mct_pkg::CNT_W-1:0];
		ns_flr = (SUM_W'(ns) > k_ext) ? ns - mct_pkg::CNT_W'(k) : '0;

		// Query terms use the unsaturated target sum.
		up_t    = over_one(sum_t) - over_one(SUM_W'(nt));
		dn_s    = over_one(SUM_W'(ns)) - over_one(SUM_W'(ns_flr));
		pres_up = (sum_t != '0) && (nt == '0);
		pres_dn = (ns != '0) && (ns_flr == '0);

		all_ok   = req.m_ok && req.s_ok && req.d_ok;
		do_src   = 1'b0;
		do_tgt   = 1'b0;
		do_query = 1'b0;
		unique case (req.kind)
			mct_pkg::KIND_ADD: begin
				do_tgt = req.m_ok && req.d_ok;
			end
			mct_pkg::KIND_MOVE: begin
				do_src = all_ok && !req.same_comm;
				do_tgt = all_ok && !req.same_comm;
			end
			mct_pkg::KIND_QUERY: begin
				do_query = all_ok;
			end
			default: begin
			end
		endcase

		upd.ns_new = ns_flr;
		upd.nt_new = nt_sat;
		upd.wr_src = do_src;
		upd.wr_tgt = do_tgt;

		upd.ss_new = ss;
		if (do_src) begin
			upd.ss_new.pres = ss.pres - mct_pkg::PRES_W'(pres_dn);
			upd.ss_new.exc  = ss.exc - mct_pkg::EXC_W'(over_one(SUM_W'(ns)))
				+ mct_pkg::EXC_W'(over_one(SUM_W'(ns_flr)));
		end

		upd.ts_new = ts;
		if (do_tgt) begin
			upd.ts_new.pres = ts.pres + mct_pkg::PRES_W'((nt == '0) && (nt_sat != '0));
			upd.ts_new.exc  = ts.exc - mct_pkg::EXC_W'(over_one(SUM_W'(nt)))
				+ mct_pkg::EXC_W'(over_one(SUM_W'(nt_sat)));
		end

		upd.ind = '0;
		upd.con = '0;
		if (do_query) begin
			upd.ind = $signed({1'b0, pres_up}) - $signed({1'b0, pres_dn});
			upd.con = $signed({1'b0, up_t[mct_pkg::CON_W-2:0]})
				- $signed({1'b0, dn_s[mct_pkg::CON_W-2:0]});
		end
	end

endmodule

>>> hw/rtl/community_marker_count_table.sv
// ----------------------------------------------------------------------------
// Community marker count table
// Per-community marker copy counts with present-type and duplicate-excess
// totals; add, move and move-query items.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  item in  | start && !busy      | kind, marker_id, copies, marker_weight,
//           |                     | src_comm, dst_comm
//  result   | done (one cycle)    | compl_delta, contam_delta,
//           |                     | source_present, source_excess,
//           |                     | target_present, target_excess
//
// After acceptance an item passes through the states RD_T, CALC and WR_T; its
// result is shown in the first cycle with busy low, the cycle the next item may
// enter.
// The count memory has one read and one write port, so the source and target
// entries are read one after the other and written back one after the other.
// After reset the block sweeps the count memory to zero, one entry a cycle,
// with busy high. Results cannot be held off.
// ----------------------------------------------------------------------------
module community_marker_count_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [mct_pkg::KIND_W-1:0]          kind,
	input  logic [mct_pkg::MARK_W-1:0]          marker_id,
	input  logic [mct_pkg::KCNT_W-1:0]          copies,
	input  logic [mct_pkg::WGT_W-1:0]           marker_weight,
	input  logic [mct_pkg::COMM_W-1:0]          src_comm,
	input  logic [mct_pkg::COMM_W-1:0]          dst_comm,
	output logic                                done,
	output logic signed [mct_pkg::DCOMP_W-1:0]  compl_delta,
	output logic signed [mct_pkg::DCONT_W-1:0]  contam_delta,
	output logic [mct_pkg::PRES_OUT_W-1:0]      source_present,
	output logic [mct_pkg::EXC_OUT_W-1:0]       source_excess,
	output logic [mct_pkg::PRES_OUT_W-1:0]      target_present,
	output logic [mct_pkg::EXC_OUT_W-1:0]       target_excess
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_T,
		ST_CALC,
		ST_WR_T
	} state_t;

	state_t                       state_q;
	logic [mct_pkg::CNT_AW-1:0]   clr_q;

	mct_pkg::req_t                req_q;
	logic [mct_pkg::MARK_W-1:0]   mark_q;
	logic [mct_pkg::KCNT_W-1:0]   k_q;
	logic [mct_pkg::WGT_W-1:0]    w_q;
	logic [mct_pkg::COMM_W-1:0]   src_q;
	logic [mct_pkg::COMM_W-1:0]   tgt_q;
	logic [mct_pkg::CNT_W-1:0]    ns_q;
	mct_pkg::stat_t               ss_q;
	mct_pkg::upd_t                upd_s3;

	mct_pkg::req_t                req_in;
	mct_pkg::upd_t                upd;
	logic                         accept;

	logic                         cnt_we;
	logic [mct_pkg::CNT_AW-1:0]   cnt_waddr;
	logic [mct_pkg::CNT_W-1:0]    cnt_wdata;
	logic [mct_pkg::CNT_AW-1:0]   cnt_raddr;
	logic [mct_pkg::CNT_W-1:0]    cnt_rdata;
	logic                         stat_we;
	logic [mct_pkg::STAT_AW-1:0]  stat_waddr;
	mct_pkg::stat_t               stat_wdata;
	logic [mct_pkg::STAT_AW-1:0]  stat_raddr;
	mct_pkg::stat_t               stat_rdata;

	logic signed [mct_pkg::DCOMP_W-1:0] dcomp;
	logic signed [mct_pkg::DCONT_W-1:0] dcont;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		req_in.kind      = kind;
		req_in.m_ok      = 32'(marker_id) < mct_pkg::NUM_MARKERS;
		req_in.s_ok      = 32'(src_comm) < mct_pkg::NUM_COMMS;
		req_in.d_ok      = 32'(dst_comm) < mct_pkg::NUM_COMMS;
		req_in.same_comm = (src_comm == dst_comm);
	end

	// The source entries are read in the accept cycle, the target ones in the cycle after it.
	always_comb begin
		if (state_q == ST_RD_T) begin
			cnt_raddr  = mct_pkg::cnt_index(tgt_q, mark_q);
			stat_raddr = mct_pkg::STAT_AW'(tgt_q);
		end else begin
			cnt_raddr  = mct_pkg::cnt_index(src_comm, marker_id);
			stat_raddr = mct_pkg::STAT_AW'(src_comm);
		end
	end

	always_comb begin
		cnt_we     = 1'b0;
		cnt_waddr  = clr_q;
		cnt_wdata  = '0;
		stat_we    = 1'b0;
		stat_waddr = clr_q[mct_pkg::STAT_AW-1:0];
		stat_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we  = 1'b1;
				stat_we = 32'(clr_q) < mct_pkg::NUM_COMMS;
			end
			ST_CALC: begin
				cnt_we     = upd.wr_src;
				cnt_waddr  = mct_pkg::cnt_index(src_q, mark_q);
				cnt_wdata  = upd.ns_new;
				stat_we    = upd.wr_src;
				stat_waddr = mct_pkg::STAT_AW'(src_q);
				stat_wdata = upd.ss_new;
			end
			ST_WR_T: begin
				cnt_we     = upd_s3.wr_tgt;
				cnt_waddr  = mct_pkg::cnt_index(tgt_q, mark_q);
				cnt_wdata  = upd_s3.nt_new;
				stat_we    = upd_s3.wr_tgt;
				stat_waddr = mct_pkg::STAT_AW'(tgt_q);
				stat_wdata = upd_s3.ts_new;
			end
			default: begin
			end
		endcase
	end

	mct_ram #(
		.WIDTH(mct_pkg::CNT_W),
		.DEPTH(mct_pkg::CNT_DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	mct_ram #(
		.WIDTH(mct_pkg::STAT_W),
		.DEPTH(mct_pkg::NUM_COMMS)
	) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (stat_waddr),
		.wdata (stat_wdata),
		.raddr (stat_raddr),
		.rdata (stat_rdata)
	);

	mct_calc u_calc (
		.req (req_q),
		.k   (k_q),
		.ns  (ns_q),
		.nt  (cnt_rdata),
		.ss  (ss_q),
		.ts  (stat_rdata),
		.upd (upd)
	);

	always_comb begin
		dcomp = $signed({{(mct_pkg::DCOMP_W - mct_pkg::WGT_W){1'b0}}, w_q})
			* mct_pkg::DCOMP_W'(upd_s3.ind);
		dcont = $signed({{(mct_pkg::DCONT_W - mct_pkg::WGT_W){1'b0}}, w_q})
			* mct_pkg::DCONT_W'(upd_s3.con);
	end

	// Item payload and the memory words read for it.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_in;
			mark_q <= marker_id;
			k_q    <= copies;
			w_q    <= marker_weight;
			src_q  <= src_comm;
			tgt_q  <= dst_comm;
		end
		if (state_q == ST_RD_T) begin
			ns_q <= cnt_rdata;
			ss_q <= stat_rdata;
		end
		if (state_q == ST_CALC) begin
			upd_s3 <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			done           <= 1'b0;
			compl_delta    <= '0;
			contam_delta   <= '0;
			source_present <= '0;
			source_excess  <= '0;
			target_present <= '0;
			target_excess  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == mct_pkg::CNT_AW'(mct_pkg::CNT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RD_T;
					end
				end
				ST_RD_T: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_WR_T;
				end
				ST_WR_T: begin
					state_q      <= ST_IDLE;
					done         <= 1'b1;
					compl_delta  <= dcomp;
					contam_delta <= dcont;
					if (req_q.kind == mct_pkg::KIND_ADD || !req_q.s_ok) begin
						source_present <= '0;
						source_excess  <= '0;
					end else begin
						source_present <= mct_pkg::sat_pres(upd_s3.ss_new.pres);
						source_excess  <= mct_pkg::sat_exc(upd_s3.ss_new.exc);
					end
					if (!req_q.d_ok) begin
						target_present <= '0;
						target_excess  <= '0;
					end else begin
						target_present <= mct_pkg::sat_pres(upd_s3.ts_new.pres);
						target_excess  <= mct_pkg::sat_exc(upd_s3.ts_new.exc);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/mct_checker.sv
// ----------------------------------------------------------------------------
// Marker count table checker
// Port-level checks of item timing, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted item is always followed by its result strobe.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result did not follow an accepted item in four cycles");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

bind community_marker_count_table mct_checker u_mct_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
